// File: design/tnfp_pkg.sv
`timescale 1ns / 1ps

package tnfp_pkg;

   // Result codes carried in the status field.
   localparam logic [2:0] ST_PUSHED    = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_ZERO_DUR  = 3'd2;
   localparam logic [2:0] ST_TICK_IDLE = 3'd3;
   localparam logic [2:0] ST_PLAYED    = 3'd4;

   // Request kinds.
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Register file.
   localparam int          CSR_ADDR_W  = 3;
   localparam logic        CSR_IDX_GAP = 1'b0;
   localparam logic [7:0]  GAP_RESET   = 8'd10;

   localparam logic [16:0] ELAPSED_MAX = 17'd65536;
   localparam logic [3:0]  FILL_MAX    = 4'd15;

   typedef struct packed {
      logic        req_type;
      logic [15:0] note_freq;
      logic [15:0] note_dur;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] tone_freq;
      logic [15:0] tone_dur;
      logic [3:0]  fill_level;
   } rsp_word_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

// File: design/timed_note_fifo_player_core.sv
`timescale 1ns / 1ps

// Timed note ring player. In the cycle in which start is taken, the
// frequency and duration memories are read at the head slot and the
// frequency memory also at the slot after it; in the following cycle the
// word is executed and the memories are written back. The result is
// driven on rsp_data for exactly one cycle, marked by rsp_valid, in the
// cycle after that; the receiver cannot hold it off, so it must take every
// result as it comes. busy is low again in the cycle in which the result
// is shown, so a new word may be started then, not while one executes. No
// clearing pass is needed after reset: slots that have never been written
// are tracked by a count of written slots and read as a frequency of zero.
module timed_note_fifo_player_core #(
   parameter int RING_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel.
   input  logic                                start,
   output logic                                busy,
   input  tnfp_pkg::req_word_type              req_data,
   // Result channel.
   output logic                                rsp_valid,
   output tnfp_pkg::rsp_word_type              rsp_data,
   // Register port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tnfp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import tnfp_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // The two note stores.
   logic [15:0] freq_mem [RING_DEPTH];
   logic [15:0] dur_mem  [RING_DEPTH];

   state_type      state_ff, state_in;
   req_word_type   req_ff;
   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0] tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0] wr_count_ff, wr_count_in;
   logic [16:0]    elapsed_ff, elapsed_in;
   logic [15:0]    wait_ff, wait_in;
   logic [7:0]     gap_ff;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_ff, rsp_in;

   logic [15:0]    head_freq_ff, next_freq_ff, head_dur_ff;
   logic           next_known_ff;

   logic           accept;
   logic           mem_we;
   logic [PTR_W-1:0] head_next, tail_next;

   assign accept    = start && !busy;
   assign head_next = ring_next(head_ptr_ff);
   assign tail_next = ring_next(tail_ptr_ff);

   // Register port: pready is always high, and a write lands on the access
   // cycle. Only the upper address bit picks the register.
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1] == CSR_IDX_GAP) begin
         gap_ff <= pwdata[7:0];
      end
   end
   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1] == CSR_IDX_GAP) begin
         prdata = {24'd0, gap_ff};
      end
   end

   // Sequencer: the accept cycle issues the reads, the execute cycle uses
   // them. Being busy in the execute cycle keeps a read from ever meeting a
   // write to the same slot.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b0;
      unique case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_EXEC:  busy = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   // Memories: registered reads at the head (frequency also at the next slot),
   // written at the tail when a push is stored.
   always_ff @(posedge clock) begin
      if (accept) begin
         head_freq_ff <= freq_mem[head_ptr_ff];
         next_freq_ff <= freq_mem[head_next];
         head_dur_ff  <= dur_mem[head_ptr_ff];
      end
      if (mem_we) begin
         freq_mem[tail_ptr_ff] <= req_ff.note_freq;
         dur_mem[tail_ptr_ff]  <= req_ff.note_dur;
      end
   end

   // Execute step.
   always_comb begin
      logic [16:0]      elapsed_inc;
      logic [15:0]      next_freq;
      logic [15:0]      gap_ext;
      logic [CNT_W-1:0] fill;

      head_ptr_in = head_ptr_ff;
      tail_ptr_in = tail_ptr_ff;
      wr_count_in = wr_count_ff;
      elapsed_in  = elapsed_ff;
      wait_in     = wait_ff;
      mem_we      = 1'b0;
      rsp_in      = '0;

      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 17'd1;
      // A slot that was never written reads as frequency zero.
      next_freq   = next_known_ff ? next_freq_ff : 16'd0;
      gap_ext     = {8'd0, gap_ff};

      if (state_ff == S_EXEC) begin
         if (req_ff.req_type == REQ_PUSH) begin
            if (tail_next == head_ptr_ff) begin
               rsp_in.status = ST_FULL;
            end else if (req_ff.note_dur == 16'd0) begin
               rsp_in.status = ST_ZERO_DUR;
            end else begin
               mem_we      = 1'b1;
               tail_ptr_in = tail_next;
               if ({1'b0, tail_ptr_ff} == (PTR_W + 1)'(wr_count_ff)) begin
                  wr_count_in = wr_count_ff + CNT_W'(1);
               end
               rsp_in.status = ST_PUSHED;
            end
         end else begin
            elapsed_in = elapsed_inc;
            if (head_ptr_ff != tail_ptr_ff && elapsed_inc > {1'b0, wait_ff}) begin
               rsp_in.tone_freq = head_freq_ff;
               rsp_in.tone_dur  = head_dur_ff;
               if (next_freq == head_freq_ff) begin
                  rsp_in.tone_dur = (head_dur_ff > gap_ext) ? head_dur_ff - gap_ext
                                                            : 16'd0;
               end
               wait_in       = head_dur_ff;
               elapsed_in    = '0;
               head_ptr_in   = head_next;
               rsp_in.status = ST_PLAYED;
            end else begin
               rsp_in.status = ST_TICK_IDLE;
            end
         end
      end

      if (tail_ptr_in >= head_ptr_in) begin
         fill = CNT_W'(tail_ptr_in) - CNT_W'(head_ptr_in);
      end else begin
         fill = CNT_W'(tail_ptr_in) + CNT_W'(RING_DEPTH) - CNT_W'(head_ptr_in);
      end
      rsp_in.fill_level = (fill > CNT_W'(FILL_MAX)) ? FILL_MAX : 4'(fill);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         wr_count_ff  <= '0;
         elapsed_ff   <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         wr_count_ff  <= wr_count_in;
         elapsed_ff   <= elapsed_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff        <= req_data;
         next_known_ff <= ({1'b0, head_next} < (PTR_W + 1)'(wr_count_ff));
      end
      if (state_ff == S_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result follows exactly one execute cycle.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_EXEC))
      else $error("result strobe without an execute cycle");

   // An accepted word always occupies the sequencer in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_valid))
      else $error("accepted word did not enter execute");

   // The tail never runs past the written region of the ring.
   a_tail_in_written: assert property (@(posedge clock) disable iff (reset)
      (PTR_W + 1)'(tail_ptr_ff) <= (PTR_W + 1)'(wr_count_ff))
      else $error("tail beyond written slots");

   // A played note restarts the elapsed counter.
   a_play_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_PLAYED) |-> (elapsed_ff == 17'd0))
      else $error("elapsed counter not cleared on play");

endmodule

// File: verif/tb_timed_note_fifo_player_core.sv
`timescale 1ns / 1ps

module tb_timed_note_fifo_player_core;
   import tnfp_pkg::*;

   // Byte address of the gap register on the register port.
   localparam logic [CSR_ADDR_W-1:0] GAP_ADDR = CSR_ADDR_W'(4 * CSR_IDX_GAP);
   // Duration of the note that the long wait test holds the ring behind.
   localparam logic [15:0] LONG_WAIT_MS = 16'd100;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_word_type          req_data;
   logic                  rsp_valid;
   rsp_word_type          rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // Our own copy of the player: the ring, its pointers, the timing state and
   // the gap register, advanced once for every word that the block accepts.
   logic [15:0] note_freqs [16];
   logic [15:0] note_durs  [16];
   logic [3:0]  ring_head;
   logic [3:0]  ring_tail;
   logic [16:0] ms_elapsed;
   logic [15:0] ms_to_wait;
   logic [7:0]  gap_setting;

   // Tone commands and statuses still owed by the block, oldest first.
   rsp_word_type  owed_results[$];
   rsp_word_type  owed_word;
   int unsigned   mismatch_count;

   // Frequencies that recur often, so that neighbouring slots match.
   logic [15:0] common_freqs [4] = '{16'd0, 16'd220, 16'd440, 16'd880};

   timed_note_fifo_player_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Clears our copy of the player to its state after reset. Durations are
   // cleared too, although no slot is ever popped before it has been written.
   task automatic clear_player_copy();
      for (int i = 0; i < 16; i++) begin
         note_freqs[i] = '0;
         note_durs[i]  = '0;
      end
      ring_head   = '0;
      ring_tail   = '0;
      ms_elapsed  = '0;
      ms_to_wait  = '0;
      gap_setting = GAP_RESET;
   endtask

   // Works out the result of one accepted word and moves our copy on.
   task automatic predict_note_result(input req_word_type w, output rsp_word_type r);
      logic [3:0]  next_slot;
      logic [15:0] played_dur;
      r = '0;
      if (w.req_type == REQ_PUSH) begin
         next_slot = ring_tail + 4'd1;
         // Fullness wins over a zero duration.
         if (next_slot == ring_head) begin
            r.status = ST_FULL;
         end else if (w.note_dur == 16'd0) begin
            r.status = ST_ZERO_DUR;
         end else begin
            note_freqs[ring_tail] = w.note_freq;
            note_durs[ring_tail]  = w.note_dur;
            ring_tail = next_slot;
            r.status = ST_PUSHED;
         end
      end else begin
         if (ms_elapsed < ELAPSED_MAX) begin
            ms_elapsed = ms_elapsed + 17'd1;
         end
         if (ring_head != ring_tail && ms_elapsed > {1'b0, ms_to_wait}) begin
            next_slot  = ring_head + 4'd1;
            played_dur = note_durs[ring_head];
            r.tone_freq = note_freqs[ring_head];
            r.tone_dur  = played_dur;
            // The slot after the head is compared even when it is stale.
            if (note_freqs[next_slot] == note_freqs[ring_head]) begin
               r.tone_dur = (played_dur > {8'd0, gap_setting}) ?
                            played_dur - {8'd0, gap_setting} : 16'd0;
            end
            ms_to_wait = played_dur;
            ms_elapsed = '0;
            ring_head  = next_slot;
            r.status   = ST_PLAYED;
         end else begin
            r.status = ST_TICK_IDLE;
         end
      end
      r.fill_level = ring_tail - ring_head;
   endtask

   // Offers one word at the falling edge and holds it until the block takes
   // it. start is left high, so that a following word goes straight out.
   task automatic send_word(input req_word_type w);
      rsp_word_type r;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      predict_note_result(w, r);
      owed_results.push_back(r);
   endtask

   task automatic push_note(input logic [15:0] freq, input logic [15:0] dur);
      send_word('{req_type: REQ_PUSH, note_freq: freq, note_dur: dur});
   endtask

   // The frequency and duration fields of a tick carry random bits, which
   // the block must ignore.
   task automatic send_tick();
      send_word('{req_type: REQ_TICK, note_freq: 16'($urandom),
                  note_dur: 16'($urandom)});
   endtask

   // Leaves start low for a pause whose length n gives.
   task automatic hold_off(input int unsigned n);
      if (n != 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Mostly no pause at all, often a short one and now and then a long one.
   task automatic random_hold_off();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)      hold_off(0);
      else if (pick < 90) hold_off($urandom_range(1, 3));
      else                hold_off($urandom_range(10, 40));
   endtask

   // Stops sending and waits until every owed result has come back.
   task automatic wait_until_quiet();
      hold_off(1);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Ticks until our copy says that the ring is empty.
   task automatic play_out_ring();
      while (ring_head != ring_tail) send_tick();
   endtask

   // Register write: a setup cycle and an access cycle. Only the low byte is
   // meaningful, so the upper bits of the data carry noise.
   task automatic write_gap(input logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= GAP_ADDR;
      pwdata  <= {24'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      gap_setting = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic log_mismatch(input string field_name, input int unsigned wanted,
                               input int unsigned seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field_name,
                  wanted, seen);
      end
   endtask

   // Every result is shown for one cycle only, so it is taken at the edge
   // that ends that cycle and compared with the oldest owed word.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (owed_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: result word with none owed", $realtime);
            end
         end else begin
            owed_word = owed_results.pop_front();
            if (rsp_data.status !== owed_word.status)
               log_mismatch("status", owed_word.status, rsp_data.status);
            if (rsp_data.tone_freq !== owed_word.tone_freq)
               log_mismatch("tone_freq", owed_word.tone_freq, rsp_data.tone_freq);
            if (rsp_data.tone_dur !== owed_word.tone_dur)
               log_mismatch("tone_dur", owed_word.tone_dur, rsp_data.tone_dur);
            if (rsp_data.fill_level !== owed_word.fill_level)
               log_mismatch("fill_level", owed_word.fill_level, rsp_data.fill_level);
         end
      end
   end

   // An idle tick on the empty ring, a note of frequency zero whose stale
   // neighbour (never written, so zero) matches it and whose short duration
   // makes the gap saturate, a zero-duration push, and a tick that plays the
   // note at once because nothing has been played yet and so nothing is
   // being waited for.
   task automatic test_first_play();
      send_tick();
      push_note(16'd0, 16'd5);
      push_note(16'd440, 16'd0);
      send_tick();
   endtask

   // Fills the ring to fifteen notes, then pushes into the full ring both a
   // normal note and a zero-duration note, which must also report full.
   task automatic test_full_ring();
      for (int i = 0; i < 15; i++) begin
         push_note((i % 3 == 2) ? 16'd880 : 16'd440, 16'(1 + i % 3));
      end
      push_note(16'd1000, 16'd7);
      push_note(16'd1000, 16'd0);
      play_out_ring();
   endtask

   // The gap at its extremes: zero leaves tones whole; 255 cuts a long note
   // part-way and a shorter one down to nothing.
   task automatic test_gap_extremes();
      wait_until_quiet();
      write_gap(8'd0);
      push_note(16'd440, 16'd4);
      push_note(16'd440, 16'd4);
      push_note(16'd1000, 16'd2);
      play_out_ring();
      wait_until_quiet();
      write_gap(8'd255);
      push_note(16'd440, 16'd300);
      push_note(16'd440, 16'd200);
      push_note(16'd440, 16'd1);
      play_out_ring();
   endtask

   // A note of the highest frequency and a long duration, then a second
   // note: the second stays idle while the elapsed count has not yet passed
   // the wait, and plays on the tick that passes it.
   task automatic test_long_wait();
      wait_until_quiet();
      write_gap(8'd10);
      push_note(16'hFFFF, LONG_WAIT_MS);
      play_out_ring();
      push_note(16'hAAAA, 16'd1);
      play_out_ring();
      send_tick();
      send_tick();
   endtask

   // A random phase under one gap setting. Most of the traffic is bursts of
   // short notes and bursts of ticks, so that the ring keeps filling and
   // playing; a few notes are long, a few pushes carry a zero duration, and
   // fully random words are pushed only into a full ring, where they are
   // refused, so that stored durations stay short enough to play out.
   task automatic run_random_phase(input int unsigned word_count, input logic [7:0] gap,
                                   input bit with_pauses);
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      logic [15:0] freq;
      logic [15:0] dur;
      sent = 0;
      wait_until_quiet();
      write_gap(gap);
      while (sent < word_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            burst = (pick < 8) ? 18 : $urandom_range(1, 8);
            repeat (burst) begin
               freq = ($urandom_range(0, 9) < 7) ? common_freqs[$urandom_range(0, 3)]
                                                 : 16'($urandom);
               pick = $urandom_range(0, 99);
               if (pick < 6)      dur = 16'd0;
               else if (pick < 9) dur = 16'($urandom_range(200, 300));
               else               dur = 16'($urandom_range(1, 6));
               push_note(freq, dur);
               sent++;
               if (with_pauses) random_hold_off();
            end
         end else if (pick < 90) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               send_tick();
               sent++;
               if (with_pauses) random_hold_off();
            end
         end else begin
            if (ring_tail + 4'd1 == ring_head) begin
               send_word('{req_type: REQ_PUSH, note_freq: 16'($urandom),
                           note_dur: 16'($urandom)});
            end else begin
               push_note(16'($urandom), 16'd0);
            end
            sent++;
            if (with_pauses) random_hold_off();
         end
      end
   endtask

   initial begin
      clock    = 1'b0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      mismatch_count = 0;
      clear_player_copy();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_play();
      test_full_ring();
      test_gap_extremes();
      test_long_wait();
      run_random_phase(180, 8'd10, 1'b1);
      run_random_phase(180, 8'd0, 1'b1);
      run_random_phase(180, 8'd255, 1'b0);
      run_random_phase(180, 8'($urandom_range(1, 254)), 1'b1);
      run_random_phase(180, 8'd1, 1'b1);

      // Let the last words come back, within a bound, then count anything
      // still owed as a failure.
      hold_off(1);
      for (int i = 0; i < 200 && owed_results.size() != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      mismatch_count += owed_results.size();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #(2_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
